FILE: src/ptmc_pkg.sv
// ----------------------------------------------------------------------------
// ptmc_pkg: shared types and constants
// Field widths, register indexes, modes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package ptmc_pkg;
   localparam int DATA_W = 16;
   localparam int ERR_W = DATA_W + 1;
   localparam int OUT_W = 16;
   localparam int GAIN_W = 16;
   localparam int MAXO_W = 15;
   localparam int REG_W = 16;
   localparam int IDX_W = 3;

   localparam logic [IDX_W-1:0] REG_MODE    = 3'd0;
   localparam logic [IDX_W-1:0] REG_KP      = 3'd1;
   localparam logic [IDX_W-1:0] REG_KI      = 3'd2;
   localparam logic [IDX_W-1:0] REG_KD      = 3'd3;
   localparam logic [IDX_W-1:0] REG_GAIN_KP = 3'd4;
   localparam logic [IDX_W-1:0] REG_CP      = 3'd5;
   localparam logic [IDX_W-1:0] REG_CI      = 3'd6;
   localparam logic [IDX_W-1:0] REG_MAX_OUT = 3'd7;

   localparam logic [1:0] MODE_POS   = 2'd0;
   localparam logic [1:0] MODE_INC   = 2'd1;
   localparam logic [1:0] MODE_ADAPT = 2'd2;

   localparam logic CMD_CLEAR = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXP, ST_GAIN, ST_MUL, ST_DONE
   } state_type;
endpackage
`default_nettype wire

FILE: src/ptmc_stream_if.sv
// ----------------------------------------------------------------------------
// ptmc_stream_if: valid/ready channel
// Carries one payload type with a source and a sink view.
// ----------------------------------------------------------------------------
`default_nettype none
interface ptmc_stream_if #(parameter int W = 16);
   logic valid;
   logic ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/ptmc_serial_mul.sv
// ----------------------------------------------------------------------------
// ptmc_serial_mul: shift-add multiplier
// Unsigned multiplicand times signed multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ptmc_serial_mul #(
   parameter int AW = 16,
   parameter int BW = 19
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [AW-1:0] a_in,
   input  wire logic signed [BW-1:0] b_in,
   output logic busy,
   output logic signed [AW+BW-1:0] prod
);
   localparam int CW = $clog2(BW + 1);
   logic [CW-1:0] cnt_ff, cnt_in;
   logic signed [AW+BW-1:0] acc_ff, acc_in;
   logic [BW-1:0] b_ff, b_in_nx;
   logic [AW+BW-1:0] a_ff, a_in_nx;
   logic signed [AW+BW-1:0] term;

   always_comb begin
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      b_in_nx = b_ff;
      a_in_nx = a_ff;
      term = signed'(a_ff);
      if (start) begin
         cnt_in = CW'(BW);
         acc_in = '0;
         b_in_nx = b_in;
         a_in_nx = {{BW{1'b0}}, a_in};
      end else if (cnt_ff != '0) begin
         // top multiplier bit has negative weight
         if (b_ff[0]) acc_in = (cnt_ff == CW'(1)) ? acc_ff - term : acc_ff + term;
         b_in_nx = b_ff >> 1;
         a_in_nx = a_ff << 1;
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      b_ff <= b_in_nx;
      a_ff <= a_in_nx;
   end

   assign busy = (cnt_ff != '0);
   assign prod = acc_ff;
endmodule
`default_nettype wire

FILE: src/ptmc_exp_rom.sv
// ----------------------------------------------------------------------------
// ptmc_exp_rom: exp(-n/16) table
// Q0.16 entries built at elaboration, registered read; out of range reads 0.
// ----------------------------------------------------------------------------
`default_nettype none
module ptmc_exp_rom #(
   parameter int DEPTH = 256
) (
   input  wire logic clock,
   input  wire logic [35:0] idx,
   output logic [15:0] q
);
   localparam int AW = $clog2(DEPTH);

   function automatic logic [15:0] entry(input int n);
      logic [63:0] v;
      logic [63:0] r;
      v = 64'd1 << 31;
      for (int k = 0; k < n; k++) v = (v * 64'd4034748383 + (64'd1 << 31)) >> 32;
      r = (v + (64'd1 << 14)) >> 15;
      return (r > 64'd65535) ? 16'hFFFF : r[15:0];
   endfunction

   logic [15:0] rom [DEPTH];
   always_comb for (int i = 0; i < DEPTH; i++) rom[i] = entry(i);

   always_ff @(posedge clock) begin
      if (idx >= 36'(DEPTH)) q <= '0;
      else q <= rom[idx[AW-1:0]];
   end
endmodule
`default_nettype wire

FILE: src/pid_three_mode_controller_core.sv
// ----------------------------------------------------------------------------
// pid_three_mode_controller_core: three-mode PID controller
// Positional, incremental and adaptive incremental control steps.
// ----------------------------------------------------------------------------
// channel  dir  payload
// req      in   cmd, feedback, setpoint
// rsp      out  drive
// csr      in   we, index, data
// Each product runs on one bit-serial multiplier (launch, a step per bit of the
// multiplier, collect). Mode 0 runs two products, mode 1 three, mode 2 six and
// two table states, and the unused mode 3 one; a clear answers on the next cycle.
// Synchronous reset clears history and control registers but sets the output
// limit to all ones. A request is taken in idle once the output register is
// empty or is being emptied in the same cycle.
`default_nettype none
module pid_three_mode_controller_core #(
   parameter int EXP_TABLE_DEPTH = 256
) (
   input wire logic clock,
   input wire logic reset,
   ptmc_stream_if.sink req,
   ptmc_stream_if.source rsp,
   input wire logic csr_we,
   input wire logic [ptmc_pkg::IDX_W-1:0] csr_index,
   input wire logic [ptmc_pkg::REG_W-1:0] csr_data
);
   localparam int EW = ptmc_pkg::ERR_W;
   localparam int DW = ptmc_pkg::DATA_W;
   localparam int BW = EW + 2;
   localparam int PW = 16 + BW;
   localparam int SW = 29;

   logic [1:0] mode_ff;
   logic [15:0] kp_ff, ki_ff, kd_ff, gkp_ff, cp_ff, ci_ff;
   logic [ptmc_pkg::MAXO_W-1:0] maxo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0; kp_ff <= '0; ki_ff <= '0; kd_ff <= '0;
         gkp_ff <= '0; cp_ff <= '0; ci_ff <= '0; maxo_ff <= '1;
      end else if (csr_we) begin
         case (csr_index)
            ptmc_pkg::REG_MODE:    mode_ff <= csr_data[1:0];
            ptmc_pkg::REG_KP:      kp_ff <= csr_data;
            ptmc_pkg::REG_KI:      ki_ff <= csr_data;
            ptmc_pkg::REG_KD:      kd_ff <= csr_data;
            ptmc_pkg::REG_GAIN_KP: gkp_ff <= csr_data;
            ptmc_pkg::REG_CP:      cp_ff <= csr_data;
            ptmc_pkg::REG_CI:      ci_ff <= csr_data;
            ptmc_pkg::REG_MAX_OUT: maxo_ff <= csr_data[ptmc_pkg::MAXO_W-1:0];
            default: ;
         endcase
      end
   end

   // products in a fixed order per mode; adaptive runs 0 1 3 2 4 5
   // 0 cp*|e| 1 ci*|e| 2 gkp*(65536-ep)(>>16) 3 ki*ei(>>16)
   // 4 p 5 i 6 d
   ptmc_pkg::state_type st_ff, st_in;
   logic [2:0] op_ff, op_in;
   logic launched_ff, launched_in;
   logic signed [EW-1:0] e0_ff, e1_ff, e2_ff;
   logic signed [EW-1:0] e0_in, e1_in, e2_in;
   logic signed [ptmc_pkg::OUT_W-1:0] acc_ff, acc_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic [35:0] xp_ff, xi_ff, xp_in, xi_in;
   logic [16:0] kpe_ff, kie_ff, kpe_in, kie_in;
   logic [15:0] ep_ff, ep_in;
   logic rsp_v_ff, rsp_v_in;
   logic [15:0] drive_ff, drive_in;
   logic cmd_w;
   logic signed [DW-1:0] fb_w, sp_w;

   logic mul_start;
   logic mul_busy;
   logic [15:0] ma;
   logic signed [BW-1:0] mb;
   logic signed [PW-1:0] prod;
   logic [15:0] rom_q;
   logic [35:0] rom_idx;

   ptmc_serial_mul #(.AW(16), .BW(BW)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a_in(ma), .b_in(mb),
      .busy(mul_busy), .prod(prod));

   ptmc_exp_rom #(.DEPTH(EXP_TABLE_DEPTH)) u_rom (
      .clock(clock), .idx(rom_idx), .q(rom_q));

   assign cmd_w = req.data[2*DW];
   assign fb_w = req.data[DW-1:0];
   assign sp_w = req.data[2*DW-1:DW];
   assign rsp.valid = rsp_v_ff;
   assign rsp.data = drive_ff;
   assign req.ready = (st_ff == ptmc_pkg::ST_IDLE) && (!rsp_v_ff || rsp.ready);
   // I-side index goes out while ep is captured, so ei is ready at the op 3 launch
   assign rom_idx = (st_ff == ptmc_pkg::ST_EXP || st_ff == ptmc_pkg::ST_GAIN) ?
                    xi_ff : xp_ff;

   logic signed [EW:0] d1, sm;
   logic signed [EW+1:0] d2;
   logic signed [EW-1:0] ae;
   logic signed [PW-1:0] sh;
   logic signed [SW-1:0] tot;
   logic signed [SW-1:0] mx;

   always_comb begin
      d1 = {e0_ff[EW-1], e0_ff} - {e1_ff[EW-1], e1_ff};
      d2 = {{2{e0_ff[EW-1]}}, e0_ff} - {e1_ff[EW-1], e1_ff, 1'b0}
           + {{2{e2_ff[EW-1]}}, e2_ff};
      sm = {e0_ff[EW-1], e0_ff} + {e1_ff[EW-1], e1_ff};
      ae = e0_ff[EW-1] ? -e0_ff : e0_ff;
      ma = '0; mb = '0;
      case (op_ff)
         3'd0: begin ma = cp_ff; mb = BW'(ae); end
         3'd1: begin ma = ci_ff; mb = BW'(ae); end
         3'd2: begin ma = gkp_ff; mb = BW'(18'h10000 - {2'b0, ep_ff}); end
         3'd3: begin ma = ki_ff; mb = BW'({1'b0, rom_q}); end
         3'd4: begin
            ma = kpe_ff[15:0];
            mb = BW'(mode_ff == ptmc_pkg::MODE_POS ? e0_ff : d1);
         end
         3'd5: begin
            ma = kie_ff[15:0];
            mb = BW'(mode_ff == ptmc_pkg::MODE_INC ? e0_ff : sm);
         end
         default: begin ma = kd_ff; mb = BW'(mode_ff == ptmc_pkg::MODE_POS ? d1 : d2); end
      endcase
   end

   // kp_eff may reach 17 bits: add its top bit times d1 separately
   logic signed [PW-1:0] extra;
   assign extra = kpe_ff[16] ? (PW'(d1) <<< 16) : '0;

   always_comb begin
      st_in = st_ff; op_in = op_ff; launched_in = launched_ff;
      e0_in = e0_ff; e1_in = e1_ff; e2_in = e2_ff; acc_in = acc_ff;
      sum_in = sum_ff; xp_in = xp_ff; xi_in = xi_ff; kpe_in = kpe_ff;
      kie_in = kie_ff; ep_in = ep_ff; rsp_v_in = rsp_v_ff; drive_in = drive_ff;
      mul_start = 1'b0;
      sh = '0; tot = '0; mx = SW'(maxo_ff);
      if (rsp_v_ff && rsp.ready) rsp_v_in = 1'b0;
      case (st_ff)
         ptmc_pkg::ST_IDLE: begin
            if (req.valid && req.ready) begin
               if (cmd_w == ptmc_pkg::CMD_CLEAR) begin
                  e0_in = '0; e1_in = '0; e2_in = '0; acc_in = '0;
                  drive_in = '0; rsp_v_in = 1'b1;
               end else begin
                  e2_in = e1_ff; e1_in = e0_ff;
                  e0_in = EW'(sp_w) - EW'(fb_w);
                  sum_in = (mode_ff == ptmc_pkg::MODE_POS) ? '0 : SW'(acc_ff);
                  kpe_in = {1'b0, kp_ff}; kie_in = {1'b0, ki_ff};
                  launched_in = 1'b0;
                  op_in = (mode_ff == ptmc_pkg::MODE_ADAPT) ? 3'd0 : 3'd4;
                  st_in = ptmc_pkg::ST_MUL;
               end
            end
         end
         ptmc_pkg::ST_EXP: begin
            // table output holds the P-side entry this cycle
            ep_in = rom_q;
            op_in = 3'd3;
            st_in = ptmc_pkg::ST_GAIN;
         end
         ptmc_pkg::ST_GAIN: begin
            st_in = ptmc_pkg::ST_MUL;
         end
         ptmc_pkg::ST_MUL: begin
            if (!launched_ff) begin
               mul_start = 1'b1; launched_in = 1'b1;
            end else if (!mul_busy) begin
               launched_in = 1'b0;
               case (op_ff)
                  3'd0: begin xp_in = 36'(prod) >> 12; op_in = 3'd1; end
                  3'd1: begin
                     xi_in = 36'(prod) >> 12; op_in = 3'd1;
                     st_in = ptmc_pkg::ST_EXP;
                  end
                  3'd2: begin
                     kpe_in = 17'(kp_ff) + 17'(prod >>> 16); op_in = 3'd4;
                  end
                  3'd3: begin kie_in = 17'(prod >>> 16); op_in = 3'd2; end
                  3'd4: begin
                     sh = (prod + extra) >>> 8; sum_in = sum_ff + SW'(sh);
                     if (mode_ff == ptmc_pkg::MODE_POS) op_in = 3'd6;
                     else op_in = 3'd5;
                     if (mode_ff != ptmc_pkg::MODE_POS && mode_ff != ptmc_pkg::MODE_INC
                         && mode_ff != ptmc_pkg::MODE_ADAPT) st_in = ptmc_pkg::ST_DONE;
                  end
                  3'd5: begin
                     sh = (mode_ff == ptmc_pkg::MODE_ADAPT) ? prod >>> 9 : prod >>> 8;
                     sum_in = sum_ff + SW'(sh);
                     op_in = 3'd6;
                     if (mode_ff == ptmc_pkg::MODE_ADAPT) st_in = ptmc_pkg::ST_DONE;
                  end
                  default: begin
                     sh = prod >>> 8; sum_in = sum_ff + SW'(sh);
                     st_in = ptmc_pkg::ST_DONE;
                  end
               endcase
            end
         end
         ptmc_pkg::ST_DONE: begin
            tot = sum_ff;
            if (mode_ff != ptmc_pkg::MODE_POS && mode_ff != ptmc_pkg::MODE_INC
                && mode_ff != ptmc_pkg::MODE_ADAPT) acc_in = acc_ff;
            else if (tot > mx) acc_in = 16'(mx);
            else if (tot < -mx) acc_in = 16'(-mx);
            else acc_in = 16'(tot);
            drive_in = acc_in; rsp_v_in = 1'b1;
            st_in = ptmc_pkg::ST_IDLE;
         end
         default: st_in = ptmc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ptmc_pkg::ST_IDLE; op_ff <= '0; launched_ff <= 1'b0;
         e0_ff <= '0; e1_ff <= '0; e2_ff <= '0; acc_ff <= '0; rsp_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in; op_ff <= op_in; launched_ff <= launched_in;
         e0_ff <= e0_in; e1_ff <= e1_in; e2_ff <= e2_in; acc_ff <= acc_in;
         rsp_v_ff <= rsp_v_in;
      end
      sum_ff <= sum_in; xp_ff <= xp_in; xi_ff <= xi_in; kpe_ff <= kpe_in;
      kie_ff <= kie_in; ep_ff <= ep_in; drive_ff <= drive_in;
   end
endmodule
`default_nettype wire

FILE: src/ptmc_checker.sv
// ----------------------------------------------------------------------------
// ptmc_checker: port-level checks
// Output handshake and clear behavior as seen at the ports.
// ----------------------------------------------------------------------------
`default_nettype none
module ptmc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic req_cmd,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [15:0] rsp_drive
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive))
      else $error("drive dropped while stalled");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd |=> rsp_valid && rsp_drive == 16'd0)
      else $error("clear did not return zero");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken with pending response");
endmodule

bind pid_three_mode_controller_core ptmc_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .req_cmd(req.data[32]), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_drive(rsp.data));
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for pid_three_mode_controller_core
// Drives control steps and clears through several gain and mode settings,
// predicts each drive value in fixed point and compares it with the output.
// ----------------------------------------------------------------------------
module tb;
   localparam int REQ_W = 1 + 2 * ptmc_pkg::DATA_W;
   localparam int TABLE_DEPTH = 256;
   localparam longint LIMIT = 4000000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [ptmc_pkg::IDX_W-1:0] csr_index;
   logic [ptmc_pkg::REG_W-1:0] csr_data;

   ptmc_stream_if #(.W(REQ_W)) req_if ();
   ptmc_stream_if #(.W(ptmc_pkg::OUT_W)) rsp_if ();

   pid_three_mode_controller_core DUT (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   typedef struct {
      logic cmd;
      logic signed [15:0] feedback;
      logic signed [15:0] setpoint;
   } step_type;

   step_type pending_q[$];
   logic [15:0] drive_q[$];
   longint unsigned exp_tab[TABLE_DEPTH];
   longint cycles;
   int fails;
   int accepted;
   int hold_left;
   bit hold_done;

   // predictor copy of registers and history
   logic [1:0] mode_r;
   longint kp_r, ki_r, kd_r, gain_kp_r, cp_r, ci_r, max_r;
   longint e_now, e_prev, e_prev2, held;

   function automatic bit quiet_window();
      return cycles > 40000 && cycles < 90000;
   endfunction

   function automatic longint exp_of(longint c, longint e);
      longint a;
      longint idx;
      a = (e < 0) ? -e : e;
      idx = (c * a) >>> 12;
      return (idx >= TABLE_DEPTH) ? 0 : longint'(exp_tab[idx]);
   endfunction

   function automatic longint clamp(longint v);
      if (v > max_r) return max_r;
      if (v < -max_r) return -max_r;
      return v;
   endfunction

   function automatic logic [15:0] drive_step(step_type s);
      longint d1, d2, p, i, d, kpe, kie;
      if (s.cmd == ptmc_pkg::CMD_CLEAR) begin
         e_now = 0; e_prev = 0; e_prev2 = 0; held = 0;
         return 16'd0;
      end
      e_prev2 = e_prev;
      e_prev = e_now;
      e_now = longint'(s.setpoint) - longint'(s.feedback);
      d1 = e_now - e_prev;
      case (mode_r)
         ptmc_pkg::MODE_POS: begin
            p = (kp_r * e_now) >>> 8;
            d = (kd_r * d1) >>> 8;
            held = clamp(p + d);
         end
         ptmc_pkg::MODE_INC: begin
            d2 = e_now - 2 * e_prev + e_prev2;
            p = (kp_r * d1) >>> 8;
            i = (ki_r * e_now) >>> 8;
            d = (kd_r * d2) >>> 8;
            held = clamp(held + p + i + d);
         end
         ptmc_pkg::MODE_ADAPT: begin
            kpe = kp_r + ((gain_kp_r * (65536 - exp_of(cp_r, e_now))) >>> 16);
            kie = (ki_r * exp_of(ci_r, e_now)) >>> 16;
            p = (kpe * d1) >>> 8;
            i = (kie * (e_now + e_prev)) >>> 9;
            held = clamp(held + p + i);
         end
         default: ;
      endcase
      return held[15:0];
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) begin
            drive_q.push_back(drive_step(pending_q[0]));
            void'(pending_q.pop_front());
            accepted <= accepted + 1;
         end
         if (pending_q.size() > 0 && (quiet_window() || $urandom_range(99) >= 33)) begin
            req_if.valid <= 1'b1;
            req_if.data <= {pending_q[0].cmd, pending_q[0].setpoint, pending_q[0].feedback};
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // monitor, with one long hold-off of the result side
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (drive_q.size() == 0) begin
               $display("%0t: unexpected drive transaction, actual %0d", $time,
                  $signed(rsp_if.data));
               fails <= fails + 1;
            end else begin
               if (rsp_if.data !== drive_q[0]) begin
                  $display("%0t: drive mismatch, expected %0d actual %0d", $time,
                     $signed(drive_q[0]), $signed(rsp_if.data));
                  fails <= fails + 1;
               end
               void'(drive_q.pop_front());
            end
         end
         if (!hold_done && accepted >= 300) begin
            hold_done <= 1'b1;
            hold_left <= 3000;
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= quiet_window() || $urandom_range(99) >= 33;
         end
      end
   end

   task automatic write_reg(logic [ptmc_pkg::IDX_W-1:0] idx, longint val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val[ptmc_pkg::REG_W-1:0];
      case (idx)
         ptmc_pkg::REG_MODE: mode_r = val[1:0];
         ptmc_pkg::REG_KP: kp_r = val & 16'hFFFF;
         ptmc_pkg::REG_KI: ki_r = val & 16'hFFFF;
         ptmc_pkg::REG_KD: kd_r = val & 16'hFFFF;
         ptmc_pkg::REG_GAIN_KP: gain_kp_r = val & 16'hFFFF;
         ptmc_pkg::REG_CP: cp_r = val & 16'hFFFF;
         ptmc_pkg::REG_CI: ci_r = val & 16'hFFFF;
         ptmc_pkg::REG_MAX_OUT: max_r = val & 15'h7FFF;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic setup(longint m, longint p, longint i, longint d, longint g, longint c0,
                        longint c1, longint mx);
      write_reg(ptmc_pkg::REG_MODE, m);
      write_reg(ptmc_pkg::REG_KP, p);
      write_reg(ptmc_pkg::REG_KI, i);
      write_reg(ptmc_pkg::REG_KD, d);
      write_reg(ptmc_pkg::REG_GAIN_KP, g);
      write_reg(ptmc_pkg::REG_CP, c0);
      write_reg(ptmc_pkg::REG_CI, c1);
      write_reg(ptmc_pkg::REG_MAX_OUT, mx);
   endtask

   task automatic add_step(logic cmd, logic [15:0] fb, logic [15:0] sp);
      step_type s;
      s.cmd = cmd;
      s.feedback = fb;
      s.setpoint = sp;
      pending_q.push_back(s);
   endtask

   task automatic add_directed();
      add_step(1'b0, 16'h8000, 16'h7FFF);
      add_step(1'b0, 16'h7FFF, 16'h8000);
      add_step(1'b0, 16'h0000, 16'h0000);
      add_step(1'b0, 16'hFFFF, 16'h0001);
      add_step(1'b1, 16'hFFFF, 16'hFFFF);
      add_step(1'b0, 16'h0005, 16'hFFFB);
   endtask

   task automatic add_random(int n);
      logic [15:0] base;
      repeat (n) begin
         base = 16'($urandom);
         case ($urandom_range(9))
            0: add_step(1'b1, 16'($urandom), 16'($urandom));
            1, 2, 3: add_step(1'b0, 16'($urandom), 16'($urandom));
            // small errors keep the adaptive table index inside its range unless cp or ci is large
            default: add_step(1'b0, base, base + 16'($urandom_range(80)) - 16'd40);
         endcase
      end
   endtask

   task automatic drain();
      wait (pending_q.size() == 0 && drive_q.size() == 0);
      repeat (5) @(posedge clock);
   endtask

   initial begin
      longint unsigned v, q;
      v = 64'd1 << 31;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         q = (v + (64'd1 << 14)) >> 15;
         exp_tab[k] = (q > 65535) ? 65535 : q;
         v = (v * 64'd4034748383 + (64'd1 << 31)) >> 32;
      end
      mode_r = ptmc_pkg::MODE_POS;
      kp_r = 0; ki_r = 0; kd_r = 0; gain_kp_r = 0; cp_r = 0; ci_r = 0; max_r = 32767;
      e_now = 0; e_prev = 0; e_prev2 = 0; held = 0;
      cycles = 0; fails = 0; accepted = 0; hold_left = 0; hold_done = 1'b0;
      csr_we = 1'b0; csr_index = '0; csr_data = '0;
      req_if.valid = 1'b0; req_if.data = '0; rsp_if.ready = 1'b0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      setup(ptmc_pkg::MODE_POS, 16'h0100, 0, 16'h0080, 0, 0, 0, 32767);
      add_directed(); add_random(90); drain();
      setup(ptmc_pkg::MODE_INC, 16'h0040, 16'h0010, 16'h0020, 0, 0, 0, 1000);
      add_directed(); add_random(90); drain();
      setup(ptmc_pkg::MODE_ADAPT, 16'h0080, 16'h0040, 0, 16'h0200, 16'h0400, 16'h0200,
         32767);
      add_directed(); add_random(90); drain();
      setup(ptmc_pkg::MODE_POS, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
         0);
      add_directed(); add_random(40); drain();
      setup(ptmc_pkg::MODE_ADAPT, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 0, 0, 32767);
      add_directed(); add_random(80); drain();
      setup(ptmc_pkg::MODE_ADAPT, 16'h0100, 16'hFFFF, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
         20000);
      add_directed(); add_random(80); drain();
      setup(2'd3, 16'h0100, 16'h0100, 16'h0100, 0, 0, 0, 32767);
      add_random(20); drain();
      for (int ph = 0; ph < 9; ph++) begin
         setup(ph % 3, $urandom, $urandom, $urandom, $urandom, $urandom_range(16'h3000),
            $urandom_range(16'h3000), $urandom_range(32767));
         add_random(80); drain();
      end

      repeat (300) @(posedge clock);
      if (fails == 0 && drive_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

FILE: sim.f
src/ptmc_pkg.sv
src/ptmc_stream_if.sv
src/ptmc_serial_mul.sv
src/ptmc_exp_rom.sv
src/pid_three_mode_controller_core.sv
src/ptmc_checker.sv
sim/tb.sv
